// File: rtl/ssclk_pkg.sv
// Shared constants, types and helpers for the serial clock setter with text frames.
`default_nettype none
package ssclk_pkg;

  localparam int TEXT_CHARS = 3;
  localparam int LINE_CHARS = 11;
  localparam int KEEP_CHARS = 3;

  localparam int TEXT_CW = $clog2(TEXT_CHARS + 1);
  localparam int TEXT_IW = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;
  localparam int LINE_CW = $clog2(LINE_CHARS + 1);
  localparam int LINE_IW = $clog2(LINE_CHARS);

  localparam int CHAR_W = 8;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int LEN_W  = 2;
  localparam int MAG_W  = 8;
  localparam int ACC_W  = 12;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
  localparam logic [MAG_W-1:0]  HOUR_LIMIT = 8'd24;
  localparam logic [MAG_W-1:0]  MIN_LIMIT  = 8'd60;
  localparam logic [ACC_W-1:0]  MAG_SAT    = 12'd255;

  localparam logic [1:0] NUM_HOUR = 2'd0;
  localparam logic [1:0] NUM_MIN  = 2'd1;
  localparam logic [1:0] NUM_SEC  = 2'd2;

  typedef struct packed {
    logic ready;
    logic accept;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ends_line;
    logic parse_last;
    logic out_busy;
  } status_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
           (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssclk_in_if.sv
// Input channel: one beat per received character or one-second tick.
`default_nettype none
interface ssclk_in_if import ssclk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] rx_char;

  modport source (output valid, output op, output rx_char, input ready);
  modport sink   (input valid, input op, input rx_char, output ready);
endinterface
`default_nettype wire

// File: rtl/ssclk_out_if.sv
// Output channel: clock value and event flags, one beat per input beat.
`default_nettype none
interface ssclk_out_if import ssclk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;
  logic [SEC_W-1:0]  seconds;
  logic              time_changed;
  logic              time_set_ok;
  logic              time_set_bad;
  logic              text_done;
  logic [LEN_W-1:0]  text_len;
  logic [CHAR_W-1:0] text_first;
  logic [CHAR_W-1:0] text_second;
  logic [CHAR_W-1:0] text_third;

  modport source (output valid, output hours, output minutes, output seconds,
                  output time_changed, output time_set_ok, output time_set_bad,
                  output text_done, output text_len, output text_first,
                  output text_second, output text_third, input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input time_changed, input time_set_ok, input time_set_bad,
                  input text_done, input text_len, input text_first,
                  input text_second, input text_third, output ready);
endinterface
`default_nettype wire

// File: rtl/ssclk_ctrl.sv
// Controller: input handshake, line parse sequencing and result hand-off.
`default_nettype none
module ssclk_ctrl import ssclk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_PARSE, S_HOLD} state_t;

  state_t state;

  always_comb begin
    cmd.ready  = (state == S_IDLE) && !status.out_busy;
    cmd.accept = cmd.ready && in_valid;
    cmd.step   = (state == S_PARSE);
    cmd.emit   = (state == S_HOLD) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && status.ends_line) state <= S_PARSE;
        end
        S_PARSE: begin
          if (status.parse_last) state <= S_HOLD;
        end
        S_HOLD: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/ssclk_dp.sv
// Datapath: framers, time line buffer, character-serial parser, clock and result register.
`default_nettype none
module ssclk_dp import ssclk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic              op,
  input  logic [CHAR_W-1:0] rx_char,
  output status_t           status,
  ssclk_out_if.source       result
);

  logic               text_open;
  logic [TEXT_CW-1:0] text_count;
  logic [CHAR_W-1:0]  text_store [TEXT_CHARS];
  logic               line_open;
  logic [LINE_CW-1:0] line_count;
  logic [CHAR_W-1:0]  line_store [LINE_CHARS];
  logic [HOUR_W-1:0]  hour_reg;
  logic [MIN_W-1:0]   minute_reg;
  logic [SEC_W-1:0]   second_reg;
  logic               out_valid;

  // parser
  logic [LINE_CW-1:0] ppos;
  logic [1:0]         pnum;
  logic               pphase;
  logic               pneg;
  logic               pdig;
  logic [MAG_W-1:0]   pmag;
  logic               pok;
  logic               res_ok;
  logic [HOUR_W-1:0]  ph;
  logic [MIN_W-1:0]   pm;
  logic [SEC_W-1:0]   ps;

  // item decode
  logic is_tick, c_open, c_text, c_close, c_bang, c_line, c_end;

  always_comb begin
    is_tick = (op == OP_TICK);
    c_open  = !is_tick && (rx_char == CH_OPEN);
    c_text  = !is_tick && !c_open && text_open;
    c_close = c_text && (rx_char == CH_CLOSE);
    c_bang  = !is_tick && !c_open && !text_open && (rx_char == CH_BANG);
    c_line  = !is_tick && !c_open && !text_open && !c_bang && line_open;
    c_end   = c_line && ((rx_char == CH_CR) || (rx_char == CH_LF));
  end

  // text frame report
  logic [4:0]        tc_ext;
  logic [LEN_W-1:0]  tlen;
  logic [CHAR_W-1:0] kept [KEEP_CHARS];

  always_comb begin
    tc_ext = 5'(text_count);
    tlen   = (tc_ext > 5'd3) ? 2'd3 : tc_ext[1:0];
    for (int i = 0; i < KEEP_CHARS; i++) begin
      kept[i] = '0;
      if ((i < TEXT_CHARS) && (i < 32'(tlen))) kept[i] = text_store[TEXT_IW'(i)];
    end
  end

  // parser step
  logic [CHAR_W-1:0] cur;
  logic              cur_digit, evalc, adv, fin, fin_ok, capture;
  logic              nphase, nneg, ndig, nok;
  logic [1:0]        nnum;
  logic [MAG_W-1:0]  nmag, limit;
  logic [ACC_W-1:0]  acc;
  logic              val_ok;

  always_comb begin
    cur = (ppos < line_count) ? line_store[ppos[LINE_IW-1:0]] : '0;
    cur_digit = (cur >= CH_ZERO) && (cur <= CH_NINE);
    acc = {pmag, 3'b000} + {3'b000, pmag, 1'b0} + {8'b0, cur[3:0]};
    limit = (pnum == NUM_HOUR) ? HOUR_LIMIT : MIN_LIMIT;
    val_ok = !(pneg && (pmag != '0)) && (pmag < limit);
    adv = 1'b0;
    fin = 1'b0;
    fin_ok = 1'b0;
    capture = 1'b0;
    evalc = 1'b0;
    nphase = pphase;
    nneg = pneg;
    ndig = pdig;
    nmag = pmag;
    nnum = pnum;
    nok = pok;
    if (!pphase) begin
      if (is_blank(cur)) begin
        adv = 1'b1;
      end else if ((cur == CH_PLUS) || (cur == CH_MINUS)) begin
        nneg = (cur == CH_MINUS);
        adv = 1'b1;
        nphase = 1'b1;
      end else begin
        evalc = 1'b1;
      end
    end else begin
      evalc = 1'b1;
    end
    if (evalc) begin
      if (cur_digit) begin
        nmag = (acc > MAG_SAT) ? MAG_SAT[MAG_W-1:0] : acc[MAG_W-1:0];
        ndig = 1'b1;
        adv = 1'b1;
        nphase = 1'b1;
      end else if (!pdig) begin
        fin = 1'b1;
      end else begin
        nok = pok && val_ok;
        capture = 1'b1;
        if (pnum == NUM_SEC) begin
          fin = 1'b1;
          fin_ok = nok;
        end else if (cur == CH_COLON) begin
          adv = 1'b1;
          nnum = pnum + 2'd1;
          nphase = 1'b0;
          nneg = 1'b0;
          ndig = 1'b0;
          nmag = '0;
        end else begin
          fin = 1'b1;
        end
      end
    end
  end

  // next clock value
  logic [HOUR_W-1:0] hr_n;
  logic [MIN_W-1:0]  mn_n;
  logic [SEC_W-1:0]  sc_n;
  logic              tick_go, set_go, load;

  always_comb begin
    tick_go = cmd.accept && is_tick;
    set_go  = cmd.emit && res_ok;
    load    = (cmd.accept && !c_end) || cmd.emit;
    hr_n = hour_reg;
    mn_n = minute_reg;
    sc_n = second_reg;
    if (tick_go) begin
      if (second_reg >= SEC_MAX) begin
        sc_n = '0;
        if (minute_reg >= MIN_MAX) begin
          mn_n = '0;
          hr_n = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 5'd1;
        end else begin
          mn_n = minute_reg + 6'd1;
        end
      end else begin
        sc_n = second_reg + 6'd1;
      end
    end else if (set_go) begin
      hr_n = ph;
      mn_n = pm;
      sc_n = ps;
    end
  end

  always_comb begin
    status.ends_line  = c_end;
    status.parse_last = fin;
    status.out_busy   = out_valid && !result.ready;
  end

  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_open  <= 1'b0;
      text_count <= '0;
      line_open  <= 1'b0;
      line_count <= '0;
      hour_reg   <= '0;
      minute_reg <= '0;
      second_reg <= '0;
      out_valid  <= 1'b0;
    end else begin
      hour_reg   <= hr_n;
      minute_reg <= mn_n;
      second_reg <= sc_n;
      if (load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      if (cmd.accept) begin
        if (c_open) begin
          text_open  <= 1'b1;
          text_count <= '0;
        end else if (c_close) begin
          text_open <= 1'b0;
        end else if (c_text) begin
          if (text_count < TEXT_CW'(TEXT_CHARS)) begin
            text_store[text_count[TEXT_IW-1:0]] <= rx_char;
            text_count <= text_count + TEXT_CW'(1);
          end
        end else if (c_bang) begin
          line_open  <= 1'b1;
          line_count <= '0;
        end else if (c_end) begin
          line_open <= 1'b0;
        end else if (c_line) begin
          if (line_count < LINE_CW'(LINE_CHARS)) begin
            line_store[line_count[LINE_IW-1:0]] <= rx_char;
            line_count <= line_count + LINE_CW'(1);
          end
        end
      end
    end
  end

  // parser and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept && c_end) begin
      ppos   <= '0;
      pnum   <= NUM_HOUR;
      pphase <= 1'b0;
      pneg   <= 1'b0;
      pdig   <= 1'b0;
      pmag   <= '0;
      pok    <= 1'b1;
    end else if (cmd.step) begin
      ppos   <= ppos + LINE_CW'(adv);
      pnum   <= nnum;
      pphase <= nphase;
      pneg   <= nneg;
      pdig   <= ndig;
      pmag   <= nmag;
      pok    <= nok;
      if (capture) begin
        case (pnum)
          NUM_HOUR: ph <= pmag[HOUR_W-1:0];
          NUM_MIN:  pm <= pmag[MIN_W-1:0];
          default:  ps <= pmag[SEC_W-1:0];
        endcase
      end
      if (fin) res_ok <= fin_ok;
    end
    if (load) begin
      result.hours        <= hr_n;
      result.minutes      <= mn_n;
      result.seconds      <= sc_n;
      result.time_changed <= tick_go || set_go;
      result.time_set_ok  <= set_go;
      result.time_set_bad <= cmd.emit && !res_ok;
      result.text_done    <= cmd.accept && c_close;
      result.text_len     <= (cmd.accept && c_close) ? tlen : '0;
      result.text_first   <= (cmd.accept && c_close) ? kept[0] : '0;
      result.text_second  <= (cmd.accept && c_close) ? kept[1] : '0;
      result.text_third   <= (cmd.accept && c_close) ? kept[2] : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/serial_set_clock_with_text_frames_top.sv
// Top level: serial clock setter with text frames.
// Usage:
//   item   (sink):   one beat per received character (op 0) or one-second tick (op 1).
//   result (source): exactly one beat per item beat, carrying the clock after
//                    the item plus time-set and text-frame flags.
// Flow: a tick or an ordinary character gives its result beat in the
//   register in the cycle after acceptance; the next item can be taken in that
//   same cycle. A CR or LF that closes a time line starts the parser, which
//   walks the buffered line one character per cycle until it finishes; the
//   result is then loaded, and no other item is taken before that.
// Stalls: the result register holds one beat; while it is full and result
//   ready is low, item ready is low and a finished parse waits.
// Reset: rst (synchronous, active high) clears the clock to 00:00:00, closes
//   both frames and empties the result register. The character buffers are
//   not cleared; only entries written in the current frame are read.
`default_nettype none
module serial_set_clock_with_text_frames_top import ssclk_pkg::*; (
  input logic          clk,
  input logic          rst,
  ssclk_in_if.sink     item,
  ssclk_out_if.source  result
);

  cmd_t    cmd;
  status_t status;

  assign item.ready = cmd.ready;

  ssclk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .status   (status),
    .cmd      (cmd)
  );

  ssclk_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .op      (item.op),
    .rx_char (item.rx_char),
    .status  (status),
    .result  (result)
  );

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |-> !(result.valid && !result.ready))
    else $error("item beat taken while result register is stalled");

  a_line_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.ends_line) |=> !item.ready)
    else $error("item ready while a time line is being parsed");

  a_emit_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.accept))
    else $error("parse result and item beat loaded in the same cycle");

  a_emit_gives_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (result.valid && (result.time_set_ok || result.time_set_bad)))
    else $error("parse finish did not produce a time-set beat");

endmodule
`default_nettype wire
